FILE: hdl/b2_pkg.sv
// shared constants, types and mixing functions for the blake2 hash engine
// no dependencies; used by b2_dp, b2_ctrl and blake2_hash_engine_top
package b2_pkg;

    localparam logic [63:0] IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [3:0] SIGMA [10][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
    };

    // fanout 1, depth 1; digest length goes in the low byte
    localparam logic [63:0] PARAM_BASE = 64'h0000_0000_0101_0000;
    localparam logic [63:0] MASK32     = 64'h0000_0000_FFFF_FFFF;
    localparam logic [3:0]  LAST_ROUND_BIG   = 4'd11;
    localparam logic [3:0]  LAST_ROUND_SMALL = 4'd9;
    localparam logic [3:0]  SIGMA_ROWS       = 4'd10;
    localparam logic [7:0]  BLOCK_BIG        = 8'd128;
    localparam logic [7:0]  BLOCK_SMALL      = 8'd64;
    localparam logic [4:0]  ALL_WORDS        = 5'd16;
    localparam logic [5:0]  DIGEST_MAX       = 6'd32;

    typedef struct packed {
        logic       accept;
        logic       store;
        logic       cnt_lo;
        logic       cnt_hi;
        logic       load;
        logic       step;
        logic       chain_upd;
        logic       emit;
        logic       fin;
        logic [3:0] round;
        logic [1:0] phase;
    } cmd_t;

    typedef struct packed {
        logic msg_open;
        logic buf_full;
        logic n_nz;
        logic out_busy;
    } status_t;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } g_t;

    function automatic logic [63:0] rotr(input logic [63:0] x, input logic is_small,
                                         input int nb, input int ns);
        logic [31:0] x32;
        x32 = x[31:0];
        if (is_small)
            return {32'b0, (x32 >> ns) | (x32 << (32 - ns))};
        return (x >> nb) | (x << (64 - nb));
    endfunction

    // one half of the mixing function: one message word, three additions
    function automatic g_t g_half(input logic [63:0] a, input logic [63:0] b,
                                  input logic [63:0] c, input logic [63:0] d,
                                  input logic [63:0] x, input logic is_small,
                                  input logic half);
        logic [63:0] mk;
        logic [63:0] t;
        logic [63:0] u;
        g_t          r;
        mk  = is_small ? MASK32 : '1;
        r.a = (a + b + x) & mk;
        t   = d ^ r.a;
        r.d = half ? rotr(t, is_small, 16, 8) : rotr(t, is_small, 32, 16);
        r.c = (c + r.d) & mk;
        u   = b ^ r.c;
        r.b = half ? rotr(u, is_small, 63, 7) : rotr(u, is_small, 24, 12);
        return r;
    endfunction

endpackage

FILE: hdl/b2_dp.sv
// datapath: chain value, byte counter, block buffer, working vector with
// four mixing lanes, and the digest output bank; depends on b2_pkg
module b2_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  b2_pkg::cmd_t     cmd,
    output b2_pkg::status_t  status,
    input  logic             is_small,
    input  logic [63:0]      seed,
    input  logic [5:0]       dig_bytes,
    input  logic [5:0]       out_bytes,
    input  logic [63:0]      in_chunk,
    input  logic [3:0]       in_bytes,
    input  logic             in_last,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [63:0]      out_word,
    output logic [1:0]       out_idx
);

    logic [63:0] chain_reg [8];
    logic [63:0] v_reg [16];
    logic [63:0] v_next [16];
    logic [63:0] blk_reg [16];
    logic [63:0] chunk_reg;
    logic [3:0]  n_reg;
    logic [7:0]  buffered_reg;
    logic        open_reg;
    logic [63:0] cnt_lo_reg;
    logic [63:0] cnt_hi_reg;
    logic        carry_reg;
    logic [4:0]  fill_reg;
    logic [63:0] dig_reg [4];
    logic        pend_reg;
    logic [1:0]  idx_reg;

    logic [3:0]  n_in;
    logic [63:0] chunk_mask;
    logic [7:0]  block;
    logic [7:0]  fill;
    logic [7:0]  fill_rnd;
    logic [7:0]  amt;
    logic [64:0] lo_sum;
    logic [63:0] mk;
    logic [3:0]  row;
    logic [63:0] m_word [4];
    logic [63:0] dig_next [4];
    logic [5:0]  ob;
    logic        open_now;

    assign open_now = cmd.accept && !open_reg;
    assign block    = is_small ? b2_pkg::BLOCK_SMALL : b2_pkg::BLOCK_BIG;
    assign mk       = is_small ? b2_pkg::MASK32 : '1;
    assign fill     = (buffered_reg < block) ? buffered_reg : block;
    assign fill_rnd = fill + 8'd7;
    assign amt      = cmd.fin ? fill : block;
    assign lo_sum   = {1'b0, cnt_lo_reg} + {57'b0, amt};
    assign row      = (cmd.round >= b2_pkg::SIGMA_ROWS) ? cmd.round - b2_pkg::SIGMA_ROWS
                                                       : cmd.round;
    assign ob       = (out_bytes > b2_pkg::DIGEST_MAX) ? b2_pkg::DIGEST_MAX : out_bytes;

    assign status.msg_open = open_reg;
    assign status.buf_full = buffered_reg >= block;
    assign status.n_nz     = n_reg != 4'd0;
    assign status.out_busy = pend_reg;

    assign out_valid = pend_reg;
    assign out_idx   = idx_reg;
    assign out_word  = dig_reg[idx_reg];

    // bytes in this item: a chunk that is not last is always full
    always_comb
    begin
        n_in = 4'd8;
        if (in_last)
            n_in = (in_bytes > 4'd8) ? 4'd8 : in_bytes;
        for (int b = 0; b < 8; b++)
            chunk_mask[8*b +: 8] = (4'(b) < n_in) ? 8'hFF : 8'h00;
    end

    // message words for the four lanes; words past the fill read as zero
    always_comb
    begin
        logic [3:0]  j;
        logic [3:0]  k;
        logic [63:0] w;
        for (int i = 0; i < 4; i++)
        begin
            j = b2_pkg::SIGMA[row][{cmd.phase[1], 2'(i), cmd.phase[0]}];
            k = is_small ? {1'b0, j[3:1]} : j;
            w = ({1'b0, k} < fill_reg) ? blk_reg[k] : '0;
            if (is_small)
                m_word[i] = j[0] ? {32'b0, w[63:32]} : {32'b0, w[31:0]};
            else
                m_word[i] = w;
        end
    end

    // phase bit 1 picks the diagonal step, bit 0 the second half
    always_comb
    begin
        logic [3:0]  ia;
        logic [3:0]  ib;
        logic [3:0]  ic;
        logic [3:0]  id;
        logic [1:0]  dg;
        b2_pkg::g_t  hg;
        v_next = v_reg;
        dg = {1'b0, cmd.phase[1]};
        for (int i = 0; i < 4; i++)
        begin
            ia = 4'(i);
            ib = {2'b01, 2'(2'(i) + dg)};
            ic = {2'b10, 2'(2'(i) + 2'(dg << 1))};
            id = {2'b11, 2'(2'(i) + 2'(dg * 2'd3))};
            hg = b2_pkg::g_half(v_reg[ia], v_reg[ib], v_reg[ic], v_reg[id],
                                m_word[i], is_small, cmd.phase[0]);
            v_next[ia] = hg.a;
            v_next[ib] = hg.b;
            v_next[ic] = hg.c;
            v_next[id] = hg.d;
        end
    end

    always_comb
    begin
        logic [63:0] w;
        for (int k = 0; k < 4; k++)
        begin
            if (is_small)
                w = {chain_reg[2*k+1][31:0], chain_reg[2*k][31:0]};
            else
                w = chain_reg[k];
            for (int b = 0; b < 8; b++)
                dig_next[k][8*b +: 8] = (6'(8*k + b) < ob) ? w[8*b +: 8] : 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg     <= 1'b0;
            buffered_reg <= '0;
            cnt_lo_reg   <= '0;
            cnt_hi_reg   <= '0;
            carry_reg    <= 1'b0;
            pend_reg     <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            if (open_now)
            begin
                open_reg     <= 1'b1;
                buffered_reg <= '0;
                cnt_lo_reg   <= '0;
                cnt_hi_reg   <= '0;
            end
            else if (cmd.emit)
                open_reg <= 1'b0;
            if (cmd.store)
                buffered_reg <= buffered_reg + {4'b0, n_reg};
            else if (cmd.chain_upd)
                buffered_reg <= '0;
            if (cmd.cnt_lo)
            begin
                cnt_lo_reg <= lo_sum[63:0];
                carry_reg  <= lo_sum[64];
            end
            if (cmd.cnt_hi)
                cnt_hi_reg <= cnt_hi_reg + {63'b0, carry_reg};
            if (cmd.emit)
            begin
                pend_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (pend_reg && out_ready)
            begin
                idx_reg <= idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                    pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            chunk_reg <= in_chunk & chunk_mask;
            n_reg     <= n_in;
        end
        if (open_now)
        begin
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= is_small ? {32'b0, b2_pkg::IV[i][63:32]} : b2_pkg::IV[i];
            chain_reg[0] <= (is_small ? {32'b0, b2_pkg::IV[0][63:32]} : b2_pkg::IV[0])
                            ^ b2_pkg::PARAM_BASE ^ {58'b0, dig_bytes}
                            ^ {32'b0, seed[31:0]};
            chain_reg[1] <= (is_small ? {32'b0, b2_pkg::IV[1][63:32]} : b2_pkg::IV[1])
                            ^ {32'b0, seed[63:32]};
        end
        else if (cmd.chain_upd)
        begin
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= (chain_reg[i] ^ v_reg[i] ^ v_reg[i+8]) & mk;
        end
        if (cmd.store)
            blk_reg[buffered_reg[6:3]] <= chunk_reg;
        if (cmd.cnt_lo)
            fill_reg <= cmd.fin ? fill_rnd[7:3] : b2_pkg::ALL_WORDS;
        if (cmd.load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i]   <= chain_reg[i] & mk;
                v_reg[i+8] <= is_small ? {32'b0, b2_pkg::IV[i][63:32]} : b2_pkg::IV[i];
            end
            v_reg[12] <= (is_small ? {32'b0, b2_pkg::IV[4][63:32]} : b2_pkg::IV[4])
                         ^ (is_small ? {32'b0, cnt_lo_reg[31:0]} : cnt_lo_reg);
            v_reg[13] <= (is_small ? {32'b0, b2_pkg::IV[5][63:32]} : b2_pkg::IV[5])
                         ^ (is_small ? {32'b0, cnt_lo_reg[63:32]} : cnt_hi_reg);
            if (cmd.fin)
                v_reg[14] <= ~(is_small ? {32'b0, b2_pkg::IV[6][63:32]} : b2_pkg::IV[6]) & mk;
        end
        else if (cmd.step)
            v_reg <= v_next;
        if (cmd.emit)
            dig_reg <= dig_next;
    end

endmodule

FILE: hdl/b2_ctrl.sv
// controller: sequences item intake, block compression rounds and digest hand-off
// depends on b2_pkg; drives b2_dp through cmd_t, reads status_t
module b2_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             is_small,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    input  b2_pkg::status_t  status,
    output b2_pkg::cmd_t     cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_STEP = 8'b0000_0010,
        S_CNT  = 8'b0000_0100,
        S_HI   = 8'b0000_1000,
        S_LOAD = 8'b0001_0000,
        S_RUN  = 8'b0010_0000,
        S_DONE = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic        last_reg, last_next;
    logic        fin_reg, fin_next;
    logic [3:0]  round_reg, round_next;
    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  last_round;

    assign last_round = is_small ? b2_pkg::LAST_ROUND_SMALL : b2_pkg::LAST_ROUND_BIG;
    assign in_ready   = state_reg == S_IDLE;

    always_comb
    begin
        state_next    = state_reg;
        last_next     = last_reg;
        fin_next      = fin_reg;
        round_next    = round_reg;
        phase_next    = phase_reg;
        cmd           = '0;
        cmd.fin       = fin_reg;
        cmd.round     = round_reg;
        cmd.phase     = phase_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    last_next  = in_last;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                // a full buffer is compressed as a non-final block only once more bytes arrive
                if (status.n_nz && status.buf_full)
                begin
                    fin_next   = 1'b0;
                    state_next = S_CNT;
                end
                else
                begin
                    cmd.store = status.n_nz;
                    if (last_reg)
                    begin
                        fin_next   = 1'b1;
                        state_next = S_CNT;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            S_CNT:
            begin
                cmd.cnt_lo = 1'b1;
                state_next = S_HI;
            end
            S_HI:
            begin
                cmd.cnt_hi = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                round_next = '0;
                phase_next = '0;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                cmd.step   = 1'b1;
                phase_next = phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    if (round_reg == last_round)
                        state_next = S_DONE;
                    else
                        round_next = round_reg + 4'd1;
                end
            end
            S_DONE:
            begin
                cmd.chain_upd = 1'b1;
                state_next    = fin_reg ? S_EMIT : S_STEP;
            end
            S_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            round_reg <= '0;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            fin_reg   <= fin_next;
            round_reg <= round_next;
            phase_reg <= phase_next;
        end
    end

endmodule

FILE: hdl/blake2_hash_engine_top.sv
// top level of the seeded blake2b / blake2s hash engine: register port and stream ports
// depends on b2_pkg, b2_ctrl and b2_dp
//
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  chunk bytes, byte count; s_tlast ends message
// m_*       out        m_tvalid/m_tready  digest word, word index; m_tlast on word 3
// apb       in/out     psel/penable       0x00 variant, 0x08 seed, 0x10 digest, 0x18 output
//
// an item needing no compression is accepted in the idle state and stored in the step state
// a block compression runs the counter, load, round and chain-update states, 12 rounds
// for blake2b and 10 for blake2s; four shared half-mixing lanes do one half-step per cycle
// the final item then hands the digest to a four-word output bank; the next message
// may start while it drains, and a further digest waits until the bank is empty
// reset clears control state only, no clearing pass
module blake2_hash_engine_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // message_chunk[63:0], chunk_bytes[67:64], zero
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // digest_word[63:0], word_index[65:64], zero
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam logic [1:0] REG_VARIANT = 2'd0;
    localparam logic [1:0] REG_SEED    = 2'd1;
    localparam logic [1:0] REG_DIGEST  = 2'd2;
    localparam logic [1:0] REG_OUTPUT  = 2'd3;

    logic        small_reg;
    logic [63:0] seed_reg;
    logic [5:0]  dig_reg;
    logic [5:0]  outb_reg;
    logic        wr_en;

    b2_pkg::cmd_t    cmd;
    b2_pkg::status_t status;
    logic [63:0]     out_word;
    logic [1:0]      out_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_reg <= 1'b0;
            seed_reg  <= '0;
            dig_reg   <= b2_pkg::DIGEST_MAX;
            outb_reg  <= b2_pkg::DIGEST_MAX;
        end
        else if (wr_en)
        begin
            unique case (paddr[4:3])
                REG_VARIANT: small_reg <= pwdata[0];
                REG_SEED:    seed_reg  <= pwdata;
                REG_DIGEST:  dig_reg   <= pwdata[5:0];
                REG_OUTPUT:  outb_reg  <= pwdata[5:0];
                default:     small_reg <= small_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:3])
            REG_VARIANT: prdata = {63'b0, small_reg};
            REG_SEED:    prdata = seed_reg;
            REG_DIGEST:  prdata = {58'b0, dig_reg};
            REG_OUTPUT:  prdata = {58'b0, outb_reg};
            default:     prdata = '0;
        endcase
    end

    b2_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .is_small (small_reg),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    b2_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .is_small  (small_reg),
        .seed      (seed_reg),
        .dig_bytes (dig_reg),
        .out_bytes (outb_reg),
        .in_chunk  (s_tdata[63:0]),
        .in_bytes  (s_tdata[67:64]),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word),
        .out_idx   (out_idx)
    );

    assign m_tdata = {6'b0, out_idx, out_word};
    assign m_tlast = out_idx == 2'd3;

endmodule

FILE: tb/b2_digest_checker.sv
// digest checker for the blake2 hash engine: watches the chunk and digest streams,
// predicts each digest from its own model of the compression and compares word by word
// depends on b2_pkg for the IV and the message schedule table
module b2_digest_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_small,
    input  logic [63:0] cfg_seed,
    input  logic [5:0]  cfg_digest,
    input  logic [5:0]  cfg_output,
    output int          fail_count,
    output int          pending_words,
    output int          digests_seen
);

    typedef struct packed {
        logic [63:0] word;
        logic [1:0]  index;
        logic        last;
    } digest_word_t;

    digest_word_t expected_words[$];
    logic [63:0]  chain[8];
    logic [63:0]  count_lo;
    logic [63:0]  count_hi;
    logic [63:0]  blk[16];
    logic [7:0]   held_bytes;
    logic         msg_open;

    assign pending_words = expected_words.size();

    function automatic logic [63:0] ror(logic [63:0] x, int n, logic sm);
        if (sm)
            return {32'b0, (x[31:0] >> n) | (x[31:0] << (32 - n))};
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic mix_step(inout logic [63:0] v[16], input int a, input int b,
                            input int c, input int d, input logic [63:0] x,
                            input logic [63:0] y, input logic sm);
        logic [63:0] mk;
        mk = sm ? 64'hFFFF_FFFF : '1;
        v[a] = (v[a] + v[b] + x) & mk;
        v[d] = ror(v[d] ^ v[a], sm ? 16 : 32, sm);
        v[c] = (v[c] + v[d]) & mk;
        v[b] = ror(v[b] ^ v[c], sm ? 12 : 24, sm);
        v[a] = (v[a] + v[b] + y) & mk;
        v[d] = ror(v[d] ^ v[a], sm ? 8 : 16, sm);
        v[c] = (v[c] + v[d]) & mk;
        v[b] = ror(v[b] ^ v[c], sm ? 7 : 63, sm);
    endtask

    task automatic compress_block(input logic sm, input logic fin);
        logic [63:0] v[16];
        logic [63:0] m[16];
        logic [63:0] mk;
        int s[16];
        mk = sm ? 64'hFFFF_FFFF : '1;
        for (int i = 0; i < 16; i++)
            m[i] = sm ? (i[0] ? blk[i >> 1] >> 32 : blk[i >> 1] & 64'hFFFF_FFFF) : blk[i];
        for (int i = 0; i < 8; i++)
        begin
            v[i] = chain[i] & mk;
            v[i + 8] = sm ? b2_pkg::IV[i] >> 32 : b2_pkg::IV[i];
        end
        if (sm)
        begin
            v[12] ^= count_lo & 64'hFFFF_FFFF;
            v[13] ^= count_lo >> 32;
        end
        else
        begin
            v[12] ^= count_lo;
            v[13] ^= count_hi;
        end
        if (fin)
            v[14] = ~v[14] & mk;
        for (int r = 0; r < (sm ? 10 : 12); r++)
        begin
            for (int j = 0; j < 16; j++)
                s[j] = b2_pkg::SIGMA[r % 10][j];
            mix_step(v, 0, 4, 8, 12, m[s[0]], m[s[1]], sm);
            mix_step(v, 1, 5, 9, 13, m[s[2]], m[s[3]], sm);
            mix_step(v, 2, 6, 10, 14, m[s[4]], m[s[5]], sm);
            mix_step(v, 3, 7, 11, 15, m[s[6]], m[s[7]], sm);
            mix_step(v, 0, 5, 10, 15, m[s[8]], m[s[9]], sm);
            mix_step(v, 1, 6, 11, 12, m[s[10]], m[s[11]], sm);
            mix_step(v, 2, 7, 8, 13, m[s[12]], m[s[13]], sm);
            mix_step(v, 3, 4, 9, 14, m[s[14]], m[s[15]], sm);
        end
        for (int i = 0; i < 8; i++)
            chain[i] = (chain[i] ^ v[i] ^ v[i + 8]) & mk;
    endtask

    task automatic bump_count(input logic [63:0] n);
        count_lo = count_lo + n;
        if (count_lo < n)
            count_hi = count_hi + 1;
    endtask

    task automatic absorb_chunk(input logic [63:0] data, input logic [3:0] nbytes,
                                input logic fin);
        logic        sm;
        logic [7:0]  blen;
        logic [7:0]  fill;
        int          n;
        int          ob;
        int          valid;
        digest_word_t e;
        sm = cfg_small;
        blen = sm ? 8'd64 : 8'd128;
        n = 8;
        if (!msg_open)
        begin
            for (int i = 0; i < 8; i++)
                chain[i] = sm ? b2_pkg::IV[i] >> 32 : b2_pkg::IV[i];
            chain[0] ^= {58'b0, cfg_digest} | 64'h0101_0000;
            chain[0] ^= cfg_seed & 64'hFFFF_FFFF;
            chain[1] ^= cfg_seed >> 32;
            count_lo = 0;
            count_hi = 0;
            held_bytes = 0;
            msg_open = 1;
        end
        if (fin)
            n = nbytes > 8 ? 8 : nbytes;
        if (n > 0)
        begin
            if (held_bytes >= blen)
            begin
                bump_count({56'b0, blen});
                compress_block(sm, 0);
                held_bytes = 0;
            end
            if (n < 8)
                data &= (64'd1 << (8 * n)) - 1;
            blk[held_bytes[6:3]] = data;
            held_bytes = held_bytes + 8'(n);
        end
        if (!fin)
            return;
        fill = held_bytes < blen ? held_bytes : blen;
        for (int i = (fill + 7) >> 3; i < 16; i++)
            blk[i] = 0;
        bump_count({56'b0, fill});
        compress_block(sm, 1);
        msg_open = 0;
        held_bytes = 0;
        ob = cfg_output > 32 ? 32 : cfg_output;
        for (int k = 0; k < 4; k++)
        begin
            e.word = sm ? ((chain[2 * k] & 64'hFFFF_FFFF) | (chain[2 * k + 1] << 32))
                        : chain[k];
            valid = ob > 8 * k ? ob - 8 * k : 0;
            if (valid == 0)
                e.word = 0;
            else if (valid < 8)
                e.word &= (64'd1 << (8 * valid)) - 1;
            e.index = 2'(k);
            e.last = (k == 3);
            expected_words.push_back(e);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        digest_word_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
            digests_seen <= 0;
            msg_open = 0;
            held_bytes = 0;
            count_lo = 0;
            count_hi = 0;
            expected_words.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                absorb_chunk(s_tdata[63:0], s_tdata[67:64], s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected digest item %h", $time, m_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (m_tdata[63:0] !== e.word || m_tdata[65:64] !== e.index
                        || m_tlast !== e.last || m_tdata[71:66] !== 6'b0)
                    begin
                        $display({"%0t: digest mismatch exp word %h idx %0d last %b,",
                                  " got %h idx %0d last %b"},
                                 $time, e.word, e.index, e.last, m_tdata[63:0],
                                 m_tdata[65:64], m_tlast);
                        fail_count <= fail_count + 1;
                    end
                    if (e.last)
                        digests_seen <= digests_seen + 1;
                end
            end
        end
    end
endmodule

FILE: tb/tb.sv
// testbench top for blake2_hash_engine_top: clock, reset, register writes and chunk stimulus
// depends on b2_pkg, blake2_hash_engine_top and b2_digest_checker
module tb;
    localparam logic [4:0] ADDR_VARIANT = 5'h00;
    localparam logic [4:0] ADDR_SEED    = 5'h08;
    localparam logic [4:0] ADDR_DIGEST  = 5'h10;
    localparam logic [4:0] ADDR_OUTPUT  = 5'h18;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    logic        cfg_small;
    logic [63:0] cfg_seed;
    logic [5:0]  cfg_digest;
    logic [5:0]  cfg_output;
    int          fail_count;
    int          pending_words;
    int          digests_seen;
    int          cycles = 0;
    int          chunks_sent;
    bit          hold_sink;
    bit          calm;

    blake2_hash_engine_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    b2_digest_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_small(cfg_small), .cfg_seed(cfg_seed), .cfg_digest(cfg_digest),
        .cfg_output(cfg_output), .fail_count(fail_count), .pending_words(pending_words),
        .digests_seen(digests_seen)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL blake2_hash_engine_top");
            $finish;
        end
    end

    // digest side: random stall bursts, a long hold-off on request
    initial
    begin
        int burst;
        bit held;
        held = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink && !held)
            begin
                m_tready <= 1'b0;
                repeat (400) @(negedge clk);
                held = 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 15);
                m_tready <= 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic reg_write(input logic [4:0] addr, input logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            ADDR_VARIANT: cfg_small = value[0];
            ADDR_SEED:    cfg_seed = value;
            ADDR_DIGEST:  cfg_digest = value[5:0];
            default:      cfg_output = value[5:0];
        endcase
    endtask

    task automatic send_chunk(input logic [63:0] data, input logic [3:0] nbytes,
                              input logic fin);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            gap = $urandom_range(1, 15);
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, nbytes, data};
        s_tlast <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        chunks_sent++;
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // whole message: n full chunks then a flagged tail of tail_bytes
    task automatic send_message(input int full_chunks, input logic [3:0] tail_bytes);
        for (int i = 0; i < full_chunks; i++)
            send_chunk(rand64(), 4'($urandom_range(0, 15)), 1'b0);
        send_chunk(rand64(), tail_bytes, 1'b1);
    endtask

    task automatic drain();
        while (pending_words != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic set_config(input logic sm, input logic [63:0] sd, input logic [5:0] dg,
                              input logic [5:0] ob);
        drain();
        reg_write(ADDR_VARIANT, {63'b0, sm});
        reg_write(ADDR_SEED, sd);
        reg_write(ADDR_DIGEST, {58'b0, dg});
        reg_write(ADDR_OUTPUT, {58'b0, ob});
    endtask

    initial
    begin
        int len;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        chunks_sent = 0;
        hold_sink = 0;
        calm = 0;
        cfg_small = 1'b0;
        cfg_seed = '0;
        cfg_digest = 6'd32;
        cfg_output = 6'd32;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty message, tails of 1, 3, 8 and an over-long 15 bytes, block edges, all-ones data
        send_chunk('0, 4'd0, 1'b1);
        send_chunk('1, 4'd15, 1'b1);
        send_chunk('1, 4'd8, 1'b1);
        send_message(15, 4'd8);
        send_message(16, 4'd0);
        set_config(1'b1, '1, 6'd0, 6'd0);
        send_message(7, 4'd8);
        send_message(8, 4'd3);
        set_config(1'b0, 64'h0123_4567_89ab_cdef, 6'd63, 6'd63);
        send_chunk(64'h8000_0000_0000_0001, 4'd1, 1'b1);

        // mid-message variant switch with a big buffer holding 96 bytes
        send_message(0, 4'd0);
        for (int i = 0; i < 12; i++)
            send_chunk(rand64(), 4'd8, 1'b0);
        drain();
        reg_write(ADDR_VARIANT, 64'd1);
        send_chunk(rand64(), 4'd5, 1'b1);

        // random phases; long sink hold-off fills the engine
        for (int phase = 0; phase < 8; phase++)
        begin
            set_config(1'($urandom_range(0, 1)), rand64(), 6'($urandom_range(0, 63)),
                       6'($urandom_range(0, 63)));
            if (phase == 2)
                hold_sink = 1;
            if (phase == 6)
                calm = 1;
            for (int m = 0; m < 3; m++)
            begin
                len = $urandom_range(0, 3) == 0 ? $urandom_range(0, 24) : $urandom_range(0, 6);
                send_message(len, 4'($urandom_range(0, 15)));
            end
        end

        drain();
        $display("sent %0d chunks, checked %0d digests over both variants and edge settings",
                 chunks_sent, digests_seen);
        if (fail_count == 0)
            $display("PASS blake2_hash_engine_top");
        else
            $display("FAIL blake2_hash_engine_top");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/b2_pkg.sv
hdl/b2_dp.sv
hdl/b2_ctrl.sv
hdl/blake2_hash_engine_top.sv
tb/b2_digest_checker.sv
tb/tb.sv
